// File: rtl/core/msjq_pkg.sv
// ============================================================================
// Multi-server job queue package
// Shared types and codes for the multi-server job queue: the command and
// result payloads, the waiting buffer entry, event kinds and register indexes.
// ============================================================================
`default_nettype none

package msjq_pkg;

    // Default sizes for the top level parameters.
    localparam int SLOTS_DEFAULT = 8;
    localparam int DEPTH_DEFAULT = 64;

    // Field widths fixed by the interface.
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int SRV_W   = 4;
    localparam int BUSY_W  = 4;
    localparam int QLEN_W  = 7;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 2;

    // Command opcodes.
    localparam logic OP_ARRIVAL  = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Result event kinds.
    localparam logic [KIND_W-1:0] EV_STARTED   = 2'd0;
    localparam logic [KIND_W-1:0] EV_QUEUED    = 2'd1;
    localparam logic [KIND_W-1:0] EV_DROPPED   = 2'd2;
    localparam logic [KIND_W-1:0] EV_DELIVERED = 2'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_SERVER_COUNT   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BUFFER_LIMIT   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SERVICE_TICKS  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_STAMP_ON_QUEUE = 2'd3;

    // Register reset values.
    localparam logic [SRV_W-1:0]  SERVER_COUNT_RST  = 4'd1;
    localparam logic [7:0]        BUFFER_LIMIT_RST  = 8'hFF;
    localparam logic [TIME_W-1:0] SERVICE_TICKS_RST = 32'd1;

    // One command on the input side.
    typedef struct packed {
        logic              opcode;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] job_stamp;
        logic [TIME_W-1:0] now_time;
        logic              is_primary;
    } cmd_t;

    // One result on the output side.
    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [ID_W-1:0]   out_job_id;
        logic [TIME_W-1:0] out_stamp;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] elapsed;
        logic              drop_signal;
        logic              id_found;
        logic [TIME_W-1:0] delivered_total;
        logic [BUSY_W-1:0] busy_count;
        logic [QLEN_W-1:0] queue_length;
        logic              last;
    } result_t;

    // One entry of the waiting buffer.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } fifo_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/multi_server_job_queue.sv
// ============================================================================
// Multi-server job queue
// Tracks jobs in service on a small busy list and holds waiting jobs in a
// FIFO buffer; reports start, queue, drop and delivery events.
// ============================================================================
//
// Usage:
//   A command is transferred at a rising edge with start high and busy low.
//   Each result is shown on result for exactly one cycle with done high; the
//   receiver cannot stall, so it must take every result as it appears.
//   A completion gives two results (delivered, then started) when a job is
//   waiting; result.last marks the final result of a command.
//   Configuration is written through cfg_valid/cfg_index/cfg_data while the
//   block is idle; cfg_ready is always high.
// Command handling:
//   Queued or dropped arrival: the result is registered and appears in the
//   cycle after the transfer, and the next command may follow at once.
//   Direct start: one busy slot checked per cycle by the shared slot compare
//   unit searching for a free entry.
//   Completion: an id search in ST_DEL_SCAN, the delivered result in
//   ST_DEL_EMIT, then a free-slot search in ST_ADD_SCAN for the started head.
// Reset:
//   Clears the busy list, counts and FIFO pointers and loads register
//   defaults; the FIFO contents need no clearing.
//
`default_nettype none

module multi_server_job_queue
    import msjq_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cmd_t              cmd,
    output logic                   done,
    output result_t                result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0] cfg_data
);

    // Derived sizes.
    localparam int SIW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW   = $clog2(SLOTS + 1);
    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (BW > SRV_W) ? BW : SRV_W;
    localparam int QW   = (CW > 8) ? CW : 8;

    localparam logic [SIW-1:0] SLOT_LAST = SIW'(SLOTS - 1);
    localparam logic [BW-1:0]  BUSY_FULL = BW'(SLOTS);
    localparam logic [PW-1:0]  PTR_LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0]  CNT_FULL  = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEL_SCAN,
        ST_DEL_EMIT,
        ST_ADD_SCAN
    } state_t;

    // Configuration registers.
    logic [SRV_W-1:0]  server_count_reg;
    logic signed [7:0] buffer_limit_reg;
    logic [TIME_W-1:0] service_ticks_reg;
    logic              stamp_on_queue_reg;

    // Busy list, counts and FIFO pointers.
    logic [ID_W-1:0]   busy_ids_reg [SLOTS];
    logic [SLOTS-1:0]  busy_valid_reg;
    logic [BW-1:0]     busy_total_reg;
    logic [PW-1:0]     fifo_head_reg;
    logic [PW-1:0]     fifo_tail_reg;
    logic [CW-1:0]     fifo_count_reg;
    logic [TIME_W-1:0] delivery_count_reg;

    // Sequencer state and working registers.
    state_t            state_reg;
    logic [SIW-1:0]    idx_reg;
    cmd_t              cmd_reg;
    logic [ID_W-1:0]   add_id_reg;
    logic [TIME_W-1:0] add_stamp_reg;
    logic              from_queue_reg;
    logic              found_reg;
    logic              done_reg;
    result_t           result_reg;

    // Waiting buffer storage.
    fifo_entry_t       fifo_mem [DEPTH];
    fifo_entry_t       rd_data_reg;

    // Trim a busy total to the result field width.
    function automatic logic [BUSY_W-1:0] fit_busy(input logic [BW-1:0] v);
        logic [BW+BUSY_W-1:0] ext;
        ext = {{BUSY_W{1'b0}}, v};
        return ext[BUSY_W-1:0];
    endfunction

    // Trim a FIFO count to the result field width.
    function automatic logic [QLEN_W-1:0] fit_qlen(input logic [CW-1:0] v);
        logic [CW+QLEN_W-1:0] ext;
        ext = {{QLEN_W{1'b0}}, v};
        return ext[QLEN_W-1:0];
    endfunction

    // Handshake and arrival decisions taken in the idle state.
    logic        accept;
    logic        direct_start;
    logic        buf_full;
    logic        fifo_we;
    fifo_entry_t wr_entry;

    assign accept       = start && (state_reg == ST_IDLE);
    assign direct_start = CMPW'(busy_total_reg) < CMPW'(server_count_reg);
    assign buf_full     = (fifo_count_reg >= CNT_FULL) ||
                          (!buffer_limit_reg[7] &&
                           (QW'(fifo_count_reg) >= QW'(buffer_limit_reg[7:0])));
    assign fifo_we      = accept && (cmd.opcode == OP_ARRIVAL) &&
                          !direct_start && !buf_full;
    assign wr_entry.id    = cmd.job_id;
    assign wr_entry.stamp = stamp_on_queue_reg ? cmd.now_time : cmd.job_stamp;

    // Shared slot compare unit: one busy slot examined per cycle.
    logic slot_free;
    logic slot_hit;
    logic slot_end;

    assign slot_free = !busy_valid_reg[idx_reg];
    assign slot_hit  = busy_valid_reg[idx_reg] && (busy_ids_reg[idx_reg] == cmd_reg.job_id);
    assign slot_end  = (idx_reg == SLOT_LAST);

    // Pointer and count updates.
    logic [PW-1:0] tail_inc;
    logic [PW-1:0] head_inc;

    assign tail_inc = (fifo_tail_reg == PTR_LAST) ? '0 : fifo_tail_reg + 1'b1;
    assign head_inc = (fifo_head_reg == PTR_LAST) ? '0 : fifo_head_reg + 1'b1;

    // Time arithmetic on the latched command.
    logic [TIME_W-1:0] finish_calc;
    logic [TIME_W-1:0] travel_calc;
    logic [TIME_W-1:0] wait_calc;
    logic [TIME_W-1:0] delivered_next;
    logic [BW-1:0]     busy_inc;
    logic [BW-1:0]     busy_dec;

    assign finish_calc    = cmd_reg.now_time + service_ticks_reg;
    assign travel_calc    = cmd_reg.now_time - cmd_reg.job_stamp;
    assign wait_calc      = from_queue_reg ? (cmd_reg.now_time - add_stamp_reg) : '0;
    assign delivered_next = delivery_count_reg + 1'b1;
    assign busy_inc       = busy_total_reg + 1'b1;
    assign busy_dec       = (busy_total_reg != '0) ? busy_total_reg - 1'b1 : busy_total_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg   <= SERVER_COUNT_RST;
            buffer_limit_reg   <= BUFFER_LIMIT_RST;
            service_ticks_reg  <= SERVICE_TICKS_RST;
            stamp_on_queue_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SERVER_COUNT:   server_count_reg   <= cfg_data[SRV_W-1:0];
                CFG_BUFFER_LIMIT:   buffer_limit_reg   <= cfg_data[7:0];
                CFG_SERVICE_TICKS:  service_ticks_reg  <= cfg_data;
                CFG_STAMP_ON_QUEUE: stamp_on_queue_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Waiting buffer: written on a queued arrival, head read every cycle.
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_tail_reg] <= wr_entry;
        end
        rd_data_reg <= fifo_mem[fifo_head_reg];
    end

    // Busy slot ids: written when a free slot is claimed.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_ADD_SCAN) && slot_free)
        begin
            busy_ids_reg[idx_reg] <= add_id_reg;
        end
    end

    // Sequencer with its registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            idx_reg            <= '0;
            busy_valid_reg     <= '0;
            busy_total_reg     <= '0;
            fifo_head_reg      <= '0;
            fifo_tail_reg      <= '0;
            fifo_count_reg     <= '0;
            delivery_count_reg <= '0;
            from_queue_reg     <= 1'b0;
            found_reg          <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= cmd;
                        idx_reg <= '0;
                        if (cmd.opcode == OP_COMPLETE)
                        begin
                            state_reg <= ST_DEL_SCAN;
                        end
                        else if (direct_start)
                        begin
                            add_id_reg     <= cmd.job_id;
                            add_stamp_reg  <= cmd.job_stamp;
                            from_queue_reg <= 1'b0;
                            state_reg      <= ST_ADD_SCAN;
                        end
                        else
                        begin
                            // Queued or dropped: reported right away.
                            done_reg                   <= 1'b1;
                            result_reg.out_job_id      <= cmd.job_id;
                            result_reg.finish_time     <= '0;
                            result_reg.elapsed         <= '0;
                            result_reg.id_found        <= 1'b0;
                            result_reg.delivered_total <= delivery_count_reg;
                            result_reg.busy_count      <= fit_busy(busy_total_reg);
                            result_reg.last            <= 1'b1;
                            if (buf_full)
                            begin
                                result_reg.event_kind   <= EV_DROPPED;
                                result_reg.out_stamp    <= cmd.job_stamp;
                                result_reg.drop_signal  <= cmd.is_primary;
                                result_reg.queue_length <= fit_qlen(fifo_count_reg);
                            end
                            else
                            begin
                                result_reg.event_kind   <= EV_QUEUED;
                                result_reg.out_stamp    <= wr_entry.stamp;
                                result_reg.drop_signal  <= 1'b0;
                                result_reg.queue_length <= fit_qlen(fifo_count_reg + 1'b1);
                                fifo_tail_reg           <= tail_inc;
                                fifo_count_reg          <= fifo_count_reg + 1'b1;
                            end
                        end
                    end
                end

                ST_DEL_SCAN:
                begin
                    // Search the busy list for the completing id.
                    if (slot_hit)
                    begin
                        busy_valid_reg[idx_reg] <= 1'b0;
                        busy_total_reg          <= busy_dec;
                        found_reg               <= 1'b1;
                        state_reg               <= ST_DEL_EMIT;
                    end
                    else if (slot_end)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= ST_DEL_EMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                ST_DEL_EMIT:
                begin
                    // Report the delivery, then pop the head if one waits.
                    done_reg                   <= 1'b1;
                    delivery_count_reg         <= delivered_next;
                    result_reg.event_kind      <= EV_DELIVERED;
                    result_reg.out_job_id      <= cmd_reg.job_id;
                    result_reg.out_stamp       <= cmd_reg.job_stamp;
                    result_reg.finish_time     <= '0;
                    result_reg.elapsed         <= travel_calc;
                    result_reg.drop_signal     <= 1'b0;
                    result_reg.id_found        <= found_reg;
                    result_reg.delivered_total <= delivered_next;
                    result_reg.busy_count      <= fit_busy(busy_total_reg);
                    result_reg.queue_length    <= fit_qlen(fifo_count_reg);
                    if (fifo_count_reg == '0)
                    begin
                        result_reg.last <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                    else
                    begin
                        result_reg.last <= 1'b0;
                        add_id_reg      <= rd_data_reg.id;
                        add_stamp_reg   <= rd_data_reg.stamp;
                        from_queue_reg  <= 1'b1;
                        fifo_head_reg   <= head_inc;
                        fifo_count_reg  <= fifo_count_reg - 1'b1;
                        idx_reg         <= '0;
                        state_reg       <= ST_ADD_SCAN;
                    end
                end

                ST_ADD_SCAN:
                begin
                    // Claim the first free slot; a full list saturates the total.
                    if (slot_free || slot_end)
                    begin
                        done_reg                   <= 1'b1;
                        result_reg.event_kind      <= EV_STARTED;
                        result_reg.out_job_id      <= add_id_reg;
                        result_reg.out_stamp       <= add_stamp_reg;
                        result_reg.finish_time     <= finish_calc;
                        result_reg.elapsed         <= wait_calc;
                        result_reg.drop_signal     <= 1'b0;
                        result_reg.id_found        <= 1'b0;
                        result_reg.delivered_total <= delivery_count_reg;
                        result_reg.queue_length    <= fit_qlen(fifo_count_reg);
                        result_reg.last            <= 1'b1;
                        state_reg                  <= ST_IDLE;
                        if (slot_free)
                        begin
                            busy_valid_reg[idx_reg] <= 1'b1;
                            busy_total_reg          <= busy_inc;
                            result_reg.busy_count   <= fit_busy(busy_inc);
                        end
                        else
                        begin
                            busy_total_reg        <= BUSY_FULL;
                            result_reg.busy_count <= fit_busy(BUSY_FULL);
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Outputs.
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // The busy total always matches the number of occupied slots.
    a_busy_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_valid_reg) == int'(busy_total_reg))
        else $error("busy total does not match occupied slots");

    // The FIFO never holds more than its depth.
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= CNT_FULL)
        else $error("FIFO count beyond depth");

    // A result that is not the last one is followed by more work.
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> busy)
        else $error("non-final result while sequencer idle");

    // Every result follows a transfer or sequencer activity.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a command");

    // A delivered result always carries a zero finish time.
    a_delivered_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.event_kind == EV_DELIVERED)) |-> (result.finish_time == '0))
        else $error("delivered result with finish time");

endmodule

`default_nettype wire
